// ----- hw/rtl/paged_record_field_store_assert.svh -----
// Assertion macros used by the record store RTL.
`ifndef PAGED_RECORD_FIELD_STORE_ASSERT_SVH
`define PAGED_RECORD_FIELD_STORE_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define PRFS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in the cycle after a trigger.
`define PRFS_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- hw/rtl/prfs_pkg.sv -----
`timescale 1ns / 1ps
package prfs_pkg;

   localparam logic [2:0] OP_RESET  = 3'd0;
   localparam logic [2:0] OP_DEFINE = 3'd1;
   localparam logic [2:0] OP_WRITE  = 3'd2;
   localparam logic [2:0] OP_READ   = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_ALIGN = 3'd1;
   localparam logic [2:0] ST_SIZE  = 3'd2;
   localparam logic [2:0] ST_FULL  = 3'd3;
   localparam logic [2:0] ST_INDEX = 3'd4;
   localparam logic [2:0] ST_MANY  = 3'd5;

   localparam logic [3:0] ACCESS_MAX = 4'd8;

   localparam int OP_W       = 3;
   localparam int AL_W       = 8;
   localparam int SZ_W       = 8;
   localparam int IX_W       = 6;
   localparam int NB_W       = 4;
   localparam int WV_W       = 64;
   localparam int ST_W       = 3;
   localparam int RV_W       = 64;
   localparam int PP_W       = 2;
   localparam int PO_W       = 8;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 80;

   typedef struct packed {
      logic clear;
      logic wr;
   } mem_cmd_type;

endpackage

// ----- hw/rtl/prfs_data_store.sv -----
`timescale 1ns / 1ps
module prfs_data_store
   import prfs_pkg::*;
#(
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  mem_cmd_type   cmd,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wdata,
   output logic          busy,
   output logic [7:0]    rdata
);

   logic [7:0]    mem [DEPTH];
   logic [AW-1:0] clr_ff, clr_in;
   logic          busy_ff, busy_in;
   logic [AW-1:0] wa;
   logic          we;
   logic [7:0]    wd;
   logic [7:0]    rdata_ff;

   always_comb begin
      busy_in = busy_ff;
      clr_in  = clr_ff;
      if (cmd.clear) begin
         busy_in = 1'b1;
         clr_in  = '0;
      end else if (busy_ff) begin
         if (clr_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end else begin
            clr_in = clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_ff  <= clr_in;
      end
   end

   // sweep owns the port while busy
   assign wa = busy_ff ? clr_ff : addr;
   assign we = busy_ff | cmd.wr;
   assign wd = busy_ff ? 8'h00 : wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rdata_ff <= mem[wa];
   end

   assign busy  = busy_ff;
   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/paged_record_field_store.sv -----
// A new item is taken only in the idle state, once the result of the last one is in
// the output register. The single byte port of the data memory sets the per-byte cost
// of accesses and the one-byte-a-cycle clearing sweep.
// Reset: synchronous; a clearing sweep of all PAGE_BYTES*MAX_PAGES data bytes runs first.
`timescale 1ns / 1ps
`include "paged_record_field_store_assert.svh"
module paged_record_field_store
   import prfs_pkg::*;
#(
   parameter int PAGE_BYTES = 256,
   parameter int MAX_PAGES  = 4,
   parameter int MAX_FIELDS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // field_align, field_size, field_index, access_bytes, write_value
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic [OP_W-1:0]       req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status, read_value, placed_page, placed_offset
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int DEPTH = PAGE_BYTES * MAX_PAGES;
   localparam int AW    = $clog2(DEPTH);
   localparam int OW    = $clog2(PAGE_BYTES);
   localparam int CW    = OW + 1;
   localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int TW    = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
   localparam int FW    = $clog2(MAX_FIELDS + 1);
   localparam int NW    = (FW > IX_W) ? FW : IX_W;
   localparam int SW    = ((CW > 9) ? CW : 9) + 1;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b00_0000_0001,
      S_CLEAR = 10'b00_0000_0010,
      S_ALIGN = 10'b00_0000_0100,
      S_PLACE = 10'b00_0000_1000,
      S_LOOK  = 10'b00_0001_0000,
      S_BASE  = 10'b00_0010_0000,
      S_WR    = 10'b00_0100_0000,
      S_RD    = 10'b00_1000_0000,
      S_RDEND = 10'b01_0000_0000,
      S_DONE  = 10'b10_0000_0000
   } state_type;

   logic [OP_W-1:0] req_opcode;
   logic [AL_W-1:0] req_field_align;
   logic [SZ_W-1:0] req_field_size;
   logic [IX_W-1:0] req_field_index;
   logic [NB_W-1:0] req_access_bytes;
   logic [WV_W-1:0] req_write_value;

   state_type       state_ff, state_in;
   logic            pend_ff, pend_in;
   logic [FW-1:0]   fdef_ff, fdef_in;
   logic [PW-1:0]   cpg_ff, cpg_in;
   logic [CW-1:0]   coff_ff, coff_in;
   logic            rd_pend_ff, rd_pend_in;
   logic            rsp_tvalid_ff, rsp_tvalid_in;

   logic [AL_W-1:0] al_ff, al_in;
   logic [SZ_W-1:0] sz_ff, sz_in;
   logic [IX_W-1:0] ix_ff, ix_in;
   logic [NB_W-1:0] nb_ff, nb_in;
   logic [WV_W-1:0] wv_ff, wv_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic [ST_W-1:0] st_ff, st_in;
   logic [RV_W-1:0] rv_ff, rv_in;
   logic [PW-1:0]   pg_ff, pg_in;
   logic [OW-1:0]   of_ff, of_in;
   logic [SW-1:0]   start_ff, start_in;
   logic [AW-1:0]   base_ff, base_in;
   logic [OW-1:0]   boff_ff, boff_in;
   logic [2:0]      i_ff, i_in;
   logic [2:0]      lane_ff, lane_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic [PW+OW-1:0] tab [MAX_FIELDS];
   logic [PW+OW-1:0] tab_q_ff;
   logic             tab_we;
   logic [TW-1:0]    tab_wa;
   logic [PW+OW-1:0] tab_wd;
   logic [PW-1:0]    tab_pg;
   logic [OW-1:0]    tab_off;

   logic            accept;
   logic [AL_W-1:0] al_m1;
   logic [SW-1:0]   start_c;
   logic [SW-1:0]   end_c;
   logic            over;
   logic [PW:0]     pg_inc;
   logic            full;
   logic [PW-1:0]   np;
   logic [OW-1:0]   noff;
   logic [CW-1:0]   ncur;
   logic [OW-1:0]   boff_nx;
   logic            last_byte;

   mem_cmd_type     cmd;
   logic [AW-1:0]   mem_addr;
   logic            clr_busy;
   logic [7:0]      rd_q;

   assign req_opcode       = req_tuser;
   assign req_field_align  = req_tdata[7:0];
   assign req_field_size   = req_tdata[15:8];
   assign req_field_index  = req_tdata[21:16];
   assign req_access_bytes = req_tdata[25:22];
   assign req_write_value  = req_tdata[89:26];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // field placement
   assign al_m1   = al_ff - 1'b1;
   assign start_c = (SW'(coff_ff) + SW'(al_m1)) & ~SW'(al_m1);
   assign end_c   = start_ff + SW'(sz_ff);
   assign over    = end_c > SW'(PAGE_BYTES);
   assign pg_inc  = {1'b0, cpg_ff} + 1'b1;
   assign full    = over && (pg_inc >= (PW + 1)'(MAX_PAGES));
   assign np      = over ? PW'(pg_inc) : cpg_ff;
   assign noff    = over ? '0 : OW'(start_ff);
   assign ncur    = over ? CW'(sz_ff) : CW'(end_c);

   assign tab_pg    = tab_q_ff[PW+OW-1:OW];
   assign tab_off   = tab_q_ff[OW-1:0];
   assign boff_nx   = (boff_ff == OW'(PAGE_BYTES - 1)) ? '0 : boff_ff + 1'b1;
   assign last_byte = (i_ff == 3'(nb_ff - 1'b1));
   assign mem_addr  = base_ff + AW'(boff_ff);

   always_comb begin
      state_in      = state_ff;
      pend_in       = pend_ff;
      fdef_in       = fdef_ff;
      cpg_in        = cpg_ff;
      coff_in       = coff_ff;
      rd_pend_in    = (state_ff == S_RD);
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      al_in         = al_ff;
      sz_in         = sz_ff;
      ix_in         = ix_ff;
      nb_in         = nb_ff;
      wv_in         = wv_ff;
      op_in         = op_ff;
      st_in         = st_ff;
      rv_in         = rv_ff;
      pg_in         = pg_ff;
      of_in         = of_ff;
      start_in      = start_ff;
      base_in       = base_ff;
      boff_in       = boff_ff;
      i_in          = i_ff;
      lane_in       = lane_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      cmd           = '0;
      tab_we        = 1'b0;
      tab_wa        = TW'(fdef_ff);
      tab_wd        = {np, noff};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_in = 1'b1;
               op_in   = req_opcode;
               al_in   = req_field_align;
               sz_in   = req_field_size;
               ix_in   = req_field_index;
               nb_in   = req_access_bytes;
               wv_in   = req_write_value;
               st_in   = ST_OK;
               rv_in   = '0;
               pg_in   = '0;
               of_in   = '0;
               case (req_opcode)
                  OP_RESET: begin
                     fdef_in   = '0;
                     cpg_in    = '0;
                     coff_in   = '0;
                     cmd.clear = 1'b1;
                     state_in  = S_CLEAR;
                  end
                  OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = S_CLEAR;
                  end
                  OP_DEFINE: state_in = S_ALIGN;
                  OP_WRITE:  state_in = S_LOOK;
                  OP_READ:   state_in = S_LOOK;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_CLEAR: begin
            if (!clr_busy) begin
               state_in = pend_ff ? S_DONE : S_IDLE;
            end
         end
         S_ALIGN: begin
            state_in = S_DONE;
            if (fdef_ff >= FW'(MAX_FIELDS)) begin
               st_in = ST_MANY;
            end else if (al_ff == '0 || (al_ff & al_m1) != '0) begin
               st_in = ST_ALIGN;
            end else if (sz_ff == '0 || SW'(sz_ff) > SW'(PAGE_BYTES)) begin
               st_in = ST_SIZE;
            end else begin
               start_in = start_c;
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            state_in = S_DONE;
            if (full) begin
               st_in = ST_FULL;
            end else begin
               tab_we  = 1'b1;
               fdef_in = fdef_ff + 1'b1;
               cpg_in  = np;
               coff_in = ncur;
               pg_in   = np;
               of_in   = noff;
            end
         end
         S_LOOK: begin
            if (NW'(ix_ff) >= NW'(fdef_ff)) begin
               st_in    = ST_INDEX;
               state_in = S_DONE;
            end else if (nb_ff == '0 || nb_ff > ACCESS_MAX) begin
               st_in    = ST_SIZE;
               state_in = S_DONE;
            end else begin
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            pg_in    = tab_pg;
            of_in    = tab_off;
            base_in  = AW'(int'(tab_pg) * PAGE_BYTES);
            boff_in  = tab_off;
            i_in     = '0;
            state_in = (op_ff == OP_WRITE) ? S_WR : S_RD;
         end
         S_WR: begin
            cmd.wr  = 1'b1;
            wv_in   = wv_ff >> 8;
            boff_in = boff_nx;
            i_in    = i_ff + 1'b1;
            if (last_byte) begin
               state_in = S_DONE;
            end
         end
         S_RD: begin
            lane_in = i_ff;
            boff_in = boff_nx;
            i_in    = i_ff + 1'b1;
            if (last_byte) begin
               state_in = S_RDEND;
            end
         end
         S_RDEND: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tdata_in  = RSP_DATA_W'({PO_W'(of_ff), PP_W'(pg_ff), rv_ff, st_ff});
               rsp_tvalid_in = 1'b1;
               pend_in       = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (rd_pend_ff) begin
         rv_in[lane_ff*8 +: 8] = rd_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         pend_ff       <= 1'b0;
         fdef_ff       <= '0;
         cpg_ff        <= '0;
         coff_ff       <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         fdef_ff       <= fdef_in;
         cpg_ff        <= cpg_in;
         coff_ff       <= coff_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      al_ff        <= al_in;
      sz_ff        <= sz_in;
      ix_ff        <= ix_in;
      nb_ff        <= nb_in;
      wv_ff        <= wv_in;
      op_ff        <= op_in;
      st_ff        <= st_in;
      rv_ff        <= rv_in;
      pg_ff        <= pg_in;
      of_ff        <= of_in;
      start_ff     <= start_in;
      base_ff      <= base_in;
      boff_ff      <= boff_in;
      i_ff         <= i_in;
      lane_ff      <= lane_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // layout table, only entries below the field count are ever used
   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab[tab_wa] <= tab_wd;
      end
      tab_q_ff <= tab[TW'(ix_ff)];
   end

   prfs_data_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .addr  (mem_addr),
      .wdata (wv_ff[7:0]),
      .busy  (clr_busy),
      .rdata (rd_q)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `PRFS_ASSERT(a_clear_blocks, clr_busy |-> !req_tready, "item taken during data sweep")
   `PRFS_ASSERT(a_field_count, fdef_ff <= FW'(MAX_FIELDS), "field count beyond limit")
   `PRFS_ASSERT(a_err_clean, (rsp_tvalid_ff && rsp_tdata_ff[2:0] != ST_OK) |-> (rsp_tdata_ff[RSP_DATA_W-1:3] == '0), "error result carries data")
   `PRFS_ASSERT_NEXT(a_clear_start, (accept && (req_opcode == OP_RESET || req_opcode == OP_CLEAR)), clr_busy, "data sweep not started")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   import prfs_pkg::*;

   localparam int PAGE_SIZE   = 256;
   localparam int PAGE_COUNT  = 4;
   localparam int FIELD_SLOTS = 64;
   localparam int ITEM_TARGET = 1750;
   localparam int QUIET_LIMIT = 20000;
   localparam int TAIL_CYCLES = 64;
   localparam int PRINT_CAP   = 50;

   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   typedef struct {
      logic [2:0]  opcode;
      logic [7:0]  field_align;
      logic [7:0]  field_size;
      logic [5:0]  field_index;
      logic [3:0]  access_bytes;
      logic [63:0] write_value;
      bit          drain_first;
   } store_op_type;

   // status in the lowest bits
   typedef struct packed {
      logic [7:0]  placed_offset;
      logic [1:0]  placed_page;
      logic [63:0] read_value;
      logic [2:0]  status;
   } store_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   paged_record_field_store DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the block's layout and data
   logic [7:0] shadow_bytes [PAGE_SIZE*PAGE_COUNT];
   int         shadow_page   [FIELD_SLOTS];
   int         shadow_offset [FIELD_SLOTS];
   int         shadow_count;
   int         cursor_pg;
   int         cursor_off;

   store_op_type     pending_ops [$];
   store_result_type awaited_results [$];
   store_op_type     cur_op;
   store_result_type got_result;
   store_result_type want_result;

   int queued_count = 0;
   int sent_count = 0;
   int recv_count = 0;
   int error_count = 0;
   int send_gap = 0;
   int recv_hold = 0;
   int quiet_cycles = 0;
   int status_seen [8];

   function automatic int idle_draw(int n);
      if ((n / 150) % 4 == 3)
         return 0;
      return $urandom_range(0, 6);
   endfunction

   function automatic void wipe_bytes();
      foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
   endfunction

   function automatic store_result_type apply_store_op(store_op_type op);
      store_result_type r;
      int al;
      int sz;
      int start;
      int pg;
      int base;
      int ix;
      r = '0;
      al = op.field_align;
      sz = op.field_size;
      ix = op.field_index;
      case (op.opcode)
         OP_RESET: begin
            wipe_bytes();
            foreach (shadow_page[i]) begin
               shadow_page[i] = 0;
               shadow_offset[i] = 0;
            end
            shadow_count = 0;
            cursor_pg = 0;
            cursor_off = 0;
         end
         OP_DEFINE: begin
            if (shadow_count >= FIELD_SLOTS)
               r.status = ST_MANY;
            else if (al == 0 || (al & (al - 1)) != 0)
               r.status = ST_ALIGN;
            else if (sz == 0 || sz > PAGE_SIZE)
               r.status = ST_SIZE;
            else begin
               start = (cursor_off + al - 1) & ~(al - 1);
               pg = cursor_pg;
               if (start + sz > PAGE_SIZE) begin
                  pg = pg + 1;
                  start = 0;
               end
               if (pg >= PAGE_COUNT)
                  r.status = ST_FULL;
               else begin
                  shadow_page[shadow_count] = pg;
                  shadow_offset[shadow_count] = start;
                  shadow_count++;
                  cursor_pg = pg;
                  cursor_off = start + sz;
                  r.placed_page = pg[1:0];
                  r.placed_offset = start[7:0];
               end
            end
         end
         OP_WRITE, OP_READ: begin
            if (ix >= shadow_count)
               r.status = ST_INDEX;
            else if (op.access_bytes == 0 || op.access_bytes > ACCESS_MAX)
               r.status = ST_SIZE;
            else begin
               base = shadow_page[ix] * PAGE_SIZE;
               for (int i = 0; i < op.access_bytes; i++) begin
                  if (op.opcode == OP_WRITE)
                     shadow_bytes[base + (shadow_offset[ix] + i) % PAGE_SIZE] =
                        op.write_value[8*i +: 8];
                  else
                     r.read_value[8*i +: 8] =
                        shadow_bytes[base + (shadow_offset[ix] + i) % PAGE_SIZE];
               end
               r.placed_page = 2'(shadow_page[ix]);
               r.placed_offset = 8'(shadow_offset[ix]);
            end
         end
         OP_CLEAR: wipe_bytes();
         default: ;
      endcase
      return r;
   endfunction

   task automatic queue_op(input int opc, input int al, input int sz, input int ix,
                           input int nb, input logic [63:0] wv, input bit drain = 1'b0);
      store_op_type op;
      op.opcode = 3'(opc);
      op.field_align = 8'(al);
      op.field_size = 8'(sz);
      op.field_index = 6'(ix);
      op.access_bytes = 4'(nb);
      op.write_value = wv;
      op.drain_first = drain;
      pending_ops.push_back(op);
      queued_count++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = idle_draw(0);
      end else if (req_tvalid && req_tready) begin
         awaited_results.push_back(apply_store_op(cur_op));
         sent_count++;
         send_gap = idle_draw(sent_count);
         if (send_gap == 0 && pending_ops.size() > 0 && !pending_ops[0].drain_first) begin
            cur_op = pending_ops.pop_front();
            req_tdata <= {6'b0, cur_op.write_value, cur_op.access_bytes, cur_op.field_index,
                          cur_op.field_size, cur_op.field_align};
            req_tuser <= cur_op.opcode;
         end else begin
            req_tvalid <= 1'b0;
         end
      end else if (!req_tvalid) begin
         if (send_gap > 0)
            send_gap--;
         else if (pending_ops.size() > 0 &&
                  (!pending_ops[0].drain_first || awaited_results.size() == 0)) begin
            cur_op = pending_ops.pop_front();
            req_tdata <= {6'b0, cur_op.write_value, cur_op.access_bytes, cur_op.field_index,
                          cur_op.field_size, cur_op.field_align};
            req_tuser <= cur_op.opcode;
            req_tvalid <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         recv_hold = 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got_result = rsp_tdata[76:0];
         if (awaited_results.size() == 0) begin
            error_count++;
            if (error_count <= PRINT_CAP)
               $display("%0t: unexpected item, actual %h", $time, got_result);
         end else begin
            want_result = awaited_results.pop_front();
            if (got_result !== want_result || rsp_tdata[79:77] !== 3'b0) begin
               error_count++;
               if (error_count <= PRINT_CAP)
                  $display("%0t: mismatch on item %0d: expected st=%0d rd=%h pg=%0d off=%0d, actual st=%0d rd=%h pg=%0d off=%0d",
                           $time, recv_count, want_result.status, want_result.read_value,
                           want_result.placed_page, want_result.placed_offset,
                           got_result.status, got_result.read_value,
                           got_result.placed_page, got_result.placed_offset);
            end
         end
         status_seen[got_result.status]++;
         recv_count++;
         recv_hold = idle_draw(recv_count);
         if (recv_hold > 0)
            rsp_tready <= 1'b0;
      end else if (!rsp_tready) begin
         if (recv_hold > 1)
            recv_hold--;
         else begin
            recv_hold = 0;
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d results outstanding",
                     quiet_cycles, awaited_results.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      int kind;
      int n_def;
      int r;
      bit tiny;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (shadow_page[i]) begin
         shadow_page[i] = 0;
         shadow_offset[i] = 0;
      end
      wipe_bytes();
      shadow_count = 0;
      cursor_pg = 0;
      cursor_off = 0;

      // directed: error checks, page roll-over, page exhaustion, spare opcodes, clear and reset
      queue_op(OP_DEFINE, 0, 4, 0, 0, '0);
      queue_op(OP_DEFINE, 3, 4, 0, 0, '0);
      queue_op(OP_DEFINE, 1, 0, 0, 0, '0);
      queue_op(OP_WRITE, 0, 0, 0, 4, 64'h1234);
      queue_op(OP_DEFINE, 1, 5, 0, 0, '0);
      queue_op(OP_DEFINE, 128, 255, 0, 0, '0);
      queue_op(OP_DEFINE, 2, 1, 0, 0, '0);
      queue_op(OP_DEFINE, 8, 8, 0, 0, '0);
      queue_op(OP_DEFINE, 64, 255, 0, 0, '0);
      queue_op(OP_DEFINE, 1, 1, 0, 0, '0);
      queue_op(OP_DEFINE, 1, 1, 0, 0, '0);
      queue_op(OP_WRITE, 0, 0, 1, 8, '1);
      queue_op(OP_WRITE, 0, 0, 4, 8, 64'h0123_4567_89AB_CDEF);
      queue_op(OP_READ, 0, 0, 4, 8, '0);
      queue_op(OP_READ, 0, 0, 3, 8, '0);
      queue_op(OP_READ, 0, 0, 1, 0, '0);
      queue_op(OP_READ, 0, 0, 1, 9, '0);
      queue_op(OP_WRITE, 0, 0, 1, 15, '1);
      queue_op(OP_READ, 0, 0, 5, 0, '0);
      queue_op(OP_READ, 0, 0, 63, 8, '0);
      queue_op(OP_WRITE, 0, 0, 2, 1, 64'hA5);
      for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
         queue_op(op, 255, 255, 63, 15, '1);
      queue_op(OP_CLEAR, 0, 0, 0, 0, '0);
      queue_op(OP_READ, 0, 0, 1, 8, '0);
      queue_op(OP_RESET, 0, 0, 0, 0, '0, 1'b1);
      queue_op(OP_READ, 0, 0, 0, 1, '0);

      // random: layout sessions with random content, some noise
      while (queued_count < ITEM_TARGET) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            repeat ($urandom_range(3, 10))
               queue_op($urandom_range(0, 7), $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 63), $urandom_range(0, 15), rand64());
         end else begin
            tiny = (kind <= 3);
            queue_op(OP_RESET, 0, 0, 0, 0, '0, $urandom_range(0, 7) == 0);
            n_def = tiny ? $urandom_range(55, 70) : $urandom_range(3, 12);
            for (int i = 0; i < n_def; i++) begin
               if ($urandom_range(0, 15) == 0)
                  queue_op(OP_DEFINE, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 63), $urandom_range(0, 15), rand64());
               else if (tiny)
                  queue_op(OP_DEFINE, 1 << $urandom_range(0, 3), $urandom_range(1, 8),
                           $urandom_range(0, 63), $urandom_range(0, 15), rand64());
               else
                  queue_op(OP_DEFINE, 1 << $urandom_range(0, 7),
                           ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 255),
                           $urandom_range(0, 63), $urandom_range(0, 15), rand64());
               if ($urandom_range(0, 5) == 0)
                  queue_op($urandom_range(0, 1) ? OP_WRITE : OP_READ, $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, i),
                           $urandom_range(1, 8), rand64());
            end
            repeat ($urandom_range(10, 40)) begin
               r = $urandom_range(0, 99);
               if (r < 2)
                  queue_op(OP_CLEAR, 0, 0, 0, 0, '0);
               else
                  queue_op($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                           $urandom_range(0, 255), $urandom_range(0, 255),
                           (r < 12) ? $urandom_range(0, 63) : $urandom_range(0, n_def - 1),
                           (r < 20) ? $urandom_range(0, 15) : $urandom_range(1, 8),
                           rand64(), r == 99);
            end
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_ops.size() != 0 || req_tvalid || awaited_results.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d items sent, %0d results checked, %0d failures", sent_count, recv_count,
               error_count);
      $display("status seen: ok %0d, align %0d, size %0d, full %0d, index %0d, too many %0d",
               status_seen[ST_OK], status_seen[ST_ALIGN], status_seen[ST_SIZE],
               status_seen[ST_FULL], status_seen[ST_INDEX], status_seen[ST_MANY]);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/prfs_pkg.sv
hw/rtl/prfs_data_store.sv
hw/rtl/paged_record_field_store.sv
tb/testbench.sv
